/* src/tlug_pkg.sv */
// shared constants and types for the three-lcg uniform generator
`default_nettype none

package tlug_pkg;

  localparam int SEED_W    = 15;
  localparam int SEED_IN_W = 32;
  localparam int OUT_W     = 24;
  localparam int REM_W     = 16;

  localparam int DEF_MODULUS_ONE   = 30269;
  localparam int DEF_MODULUS_TWO   = 30307;
  localparam int DEF_MODULUS_THREE = 30323;
  localparam int DEF_FRACTION_BITS = 24;

  localparam int STEP_MULT_ONE   = 171;
  localparam int STEP_MULT_TWO   = 172;
  localparam int STEP_MULT_THREE = 170;

  localparam int RESEED_MULT_ONE   = 1000;
  localparam int RESEED_MULT_TWO   = 2000;
  localparam int RESEED_MULT_THREE = 3000;

  localparam int SEED_INIT_ONE   = 1000;
  localparam int SEED_INIT_TWO   = 2000;
  localparam int SEED_INIT_THREE = 3000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_LOAD_STEP,
    OP_LOAD_SCALE,
    OP_QEST,
    OP_REM,
    OP_FIX,
    OP_TMUL,
    OP_TSUM,
    OP_TREM,
    OP_TFIX,
    OP_SUM
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QEST,
    S_REM,
    S_FIX,
    S_SCALE,
    S_TMUL,
    S_TSUM,
    S_TREM,
    S_TFIX,
    S_SUM
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MODE_DRAW,
    MODE_RESEED_A,
    MODE_RESEED_B
  } ctrl_mode_t;

endpackage

`default_nettype wire

/* src/tlug_ctrl.sv */
// sequencing controller: steps the datapath through draw and reseed
`default_nettype none

module tlug_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tlug_pkg::dp_op_t      op
);
  import tlug_pkg::*;

  ctrl_state_t state, state_next;
  ctrl_mode_t  mode, mode_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_DRAW;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    op             = OP_NONE;
    out_valid_next = out_valid & out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_QEST;
          if (req_type) begin
            op        = OP_LOAD_IN;
            mode_next = MODE_RESEED_A;
          end else begin
            op        = OP_LOAD_STEP;
            mode_next = MODE_DRAW;
          end
        end
      end
      S_QEST: begin
        op         = OP_QEST;
        state_next = S_REM;
      end
      S_REM: begin
        op         = OP_REM;
        state_next = S_FIX;
      end
      S_FIX: begin
        op = OP_FIX;
        unique case (mode)
          MODE_DRAW:     state_next = S_TMUL;
          MODE_RESEED_A: state_next = S_SCALE;
          MODE_RESEED_B: state_next = S_IDLE;
          default:       state_next = S_IDLE;
        endcase
      end
      // second pass of the reseed: (seed mod m) times (k*1000 mod m)
      S_SCALE: begin
        op         = OP_LOAD_SCALE;
        mode_next  = MODE_RESEED_B;
        state_next = S_QEST;
      end
      S_TMUL: begin
        op         = OP_TMUL;
        state_next = S_TSUM;
      end
      S_TSUM: begin
        op         = OP_TSUM;
        state_next = S_TREM;
      end
      S_TREM: begin
        op         = OP_TREM;
        state_next = S_TFIX;
      end
      S_TFIX: begin
        op         = OP_TFIX;
        state_next = S_SUM;
      end
      // hold until the previous result transaction has gone
      S_SUM: begin
        if (!(out_valid && out_stall)) begin
          op             = OP_SUM;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/tlug_lane.sv */
// one congruential lane: seed register, constant modulo and term scaling
`default_nettype none

module tlug_lane #(
  parameter int MODULUS       = tlug_pkg::DEF_MODULUS_ONE,
  parameter int STEP_MULT     = tlug_pkg::STEP_MULT_ONE,
  parameter int RESEED_MULT   = tlug_pkg::RESEED_MULT_ONE,
  parameter int SEED_INIT     = tlug_pkg::SEED_INIT_ONE,
  parameter int FRACTION_BITS = tlug_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tlug_pkg::dp_op_t                    op,
  input  wire logic [tlug_pkg::SEED_IN_W-1:0]      seed_in,
  output logic      [FRACTION_BITS-1:0]            term
);
  import tlug_pkg::*;

  localparam int MT_W = FRACTION_BITS + SEED_W;
  localparam int LO_W = (MT_W + 1) / 2;
  localparam int HI_W = MT_W - LO_W;
  localparam int PW   = SEED_W + MT_W;

  // floor(2^32 / m): quotient estimate is exact or one low
  localparam logic [SEED_IN_W-1:0] MU =
    SEED_IN_W'((64'd1 << SEED_IN_W) / 64'(MODULUS));
  // floor(2^(f+15) / m) for the term, split for two narrow multipliers
  localparam logic [MT_W-1:0] MT =
    MT_W'((64'd1 << (FRACTION_BITS + SEED_W)) / 64'(MODULUS));
  localparam logic [LO_W-1:0]   MT_LO   = MT[LO_W-1:0];
  localparam logic [HI_W-1:0]   MT_HI   = MT[MT_W-1:LO_W];
  localparam logic [REM_W-1:0]  MOD_R   = REM_W'(MODULUS);
  localparam logic [7:0]        STEP_C  = 8'(STEP_MULT);
  localparam logic [SEED_W-1:0] SCALE_C = SEED_W'(RESEED_MULT % MODULUS);

  logic [SEED_W-1:0]        seed;
  logic [SEED_IN_W-1:0]     x;
  logic [REM_W-1:0]         q;
  logic [REM_W-1:0]         r;
  logic [SEED_W+LO_W-1:0]   plo;
  logic [SEED_W+HI_W-1:0]   phi;
  logic [FRACTION_BITS-1:0] est;
  logic [REM_W-1:0]         rt;

  logic [SEED_W+7:0]        step_prod;
  logic [2*SEED_W-1:0]      scale_prod;
  logic [2*SEED_IN_W-1:0]   qprod;
  logic [REM_W-1:0]         rprod;
  logic [SEED_W+LO_W-1:0]   lo_prod;
  logic [SEED_W+HI_W-1:0]   hi_prod;
  logic [PW-1:0]            tsum;
  logic [REM_W-1:0]         tprod;

  assign step_prod  = seed * STEP_C;
  assign scale_prod = seed * SCALE_C;
  assign qprod      = x * MU;
  assign rprod      = q * MOD_R;
  assign lo_prod    = seed * MT_LO;
  assign hi_prod    = seed * MT_HI;
  assign tsum       = (PW'(phi) << LO_W) + PW'(plo);
  // low bits of s*2^f are zero, so the term remainder is just -est*m
  assign tprod      = est[REM_W-1:0] * MOD_R;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_W'(SEED_INIT);
    end else begin
      case (op)
        OP_LOAD_IN:    x <= seed_in;
        OP_LOAD_STEP:  x <= SEED_IN_W'(step_prod);
        OP_LOAD_SCALE: x <= SEED_IN_W'(scale_prod);
        OP_QEST:       q <= qprod[SEED_IN_W +: REM_W];
        // remainder is below 2m, only its low bits matter
        OP_REM:        r <= x[REM_W-1:0] - rprod;
        OP_FIX:        seed <= (r >= MOD_R) ? SEED_W'(r - MOD_R) : r[SEED_W-1:0];
        OP_TMUL: begin
          plo <= lo_prod;
          phi <= hi_prod;
        end
        OP_TSUM:       est <= tsum[SEED_W +: FRACTION_BITS];
        OP_TREM:       rt <= REM_W'(0) - tprod;
        OP_TFIX:       term <= (rt >= MOD_R) ? est + FRACTION_BITS'(1) : est;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/tlug_dp.sv */
// datapath: three lanes, fraction sum and the result register
`default_nettype none

module tlug_dp #(
  parameter int MODULUS_ONE   = tlug_pkg::DEF_MODULUS_ONE,
  parameter int MODULUS_TWO   = tlug_pkg::DEF_MODULUS_TWO,
  parameter int MODULUS_THREE = tlug_pkg::DEF_MODULUS_THREE,
  parameter int FRACTION_BITS = tlug_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tlug_pkg::dp_op_t                op,
  input  wire logic [tlug_pkg::SEED_IN_W-1:0]  seed_in,
  output logic      [tlug_pkg::OUT_W-1:0]      uniform_fraction
);
  import tlug_pkg::*;

  logic [FRACTION_BITS-1:0] term_one, term_two, term_three;
  logic [FRACTION_BITS-1:0] fsum;
  logic [OUT_W-1:0]         fmt;

  tlug_lane #(
    .MODULUS(MODULUS_ONE), .STEP_MULT(STEP_MULT_ONE),
    .RESEED_MULT(RESEED_MULT_ONE), .SEED_INIT(SEED_INIT_ONE),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_one (
    .clk(clk), .rst(rst), .op(op), .seed_in(seed_in), .term(term_one)
  );

  tlug_lane #(
    .MODULUS(MODULUS_TWO), .STEP_MULT(STEP_MULT_TWO),
    .RESEED_MULT(RESEED_MULT_TWO), .SEED_INIT(SEED_INIT_TWO),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_two (
    .clk(clk), .rst(rst), .op(op), .seed_in(seed_in), .term(term_two)
  );

  tlug_lane #(
    .MODULUS(MODULUS_THREE), .STEP_MULT(STEP_MULT_THREE),
    .RESEED_MULT(RESEED_MULT_THREE), .SEED_INIT(SEED_INIT_THREE),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_three (
    .clk(clk), .rst(rst), .op(op), .seed_in(seed_in), .term(term_three)
  );

  // wraps modulo one
  assign fsum = term_one + term_two + term_three;

  generate
    if (FRACTION_BITS >= OUT_W) begin : g_trunc
      assign fmt = fsum[FRACTION_BITS-1 -: OUT_W];
    end else begin : g_pad
      assign fmt = {fsum, {(OUT_W - FRACTION_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (op == OP_SUM) begin
      uniform_fraction <= fmt;
    end
  end

endmodule

`default_nettype wire

/* src/three_lcg_uniform_generator.sv */
// Wichmann-Hill uniform generator built from three 15-bit congruential lanes.
// One transaction is taken at a time. A draw (req_type 0) steps all three
// seeds and returns one unsigned 0.24 fraction; the controller walks each lane
// through its constant-modulo steps (estimate, remainder, correct) and then
// its reciprocal term scaling (two partial products, sum, remainder, correct)
// before the sum of the three terms is written to the result register.
// A reseed (req_type 1) gives no result and makes two passes of the modulo
// steps, one on the seed and one on its product with k*1000 mod m.
// The next transaction is accepted in the cycle after either finishes; a draw
// also waits while the previous result is still stalled.
`default_nettype none

module three_lcg_uniform_generator #(
  parameter int MODULUS_ONE   = tlug_pkg::DEF_MODULUS_ONE,
  parameter int MODULUS_TWO   = tlug_pkg::DEF_MODULUS_TWO,
  parameter int MODULUS_THREE = tlug_pkg::DEF_MODULUS_THREE,
  parameter int FRACTION_BITS = tlug_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            req_type,
  input  wire logic [tlug_pkg::SEED_IN_W-1:0]  seed,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [tlug_pkg::OUT_W-1:0]      uniform_fraction
);
  import tlug_pkg::*;

  dp_op_t op;

  tlug_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .out_valid(out_valid), .out_stall(out_stall),
    .op(op)
  );

  tlug_dp #(
    .MODULUS_ONE(MODULUS_ONE), .MODULUS_TWO(MODULUS_TWO),
    .MODULUS_THREE(MODULUS_THREE), .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .op(op), .seed_in(seed),
    .uniform_fraction(uniform_fraction)
  );

endmodule

`default_nettype wire
